// ===== hdl/lss_pkg.sv =====
package lss_pkg;

   localparam int MAX_LEN_DEF   = 64;
   localparam int MAX_NAMES_DEF = 256;

   localparam logic [6:0] CH_UP_A  = 7'd65;
   localparam logic [6:0] CH_UP_Z  = 7'd90;
   localparam logic [6:0] CH_LOW_A = 7'd97;
   localparam logic [6:0] CH_LOW_Z = 7'd122;

   typedef struct packed {
      logic [6:0] letter;
      logic       end_of_name;
      logic       end_of_list;
   } req_type;

   typedef struct packed {
      logic [6:0] sorted_letter;
      logic [7:0] name_index;
      logic       last_letter;
   } rsp_type;

   // Order: A a B b ... Z z, then any other code in code order.
   function automatic logic [7:0] sort_key(input logic [6:0] c);
      logic [6:0] d;
      logic [7:0] k;
      d = 7'd0;
      if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
         d = c - CH_LOW_A;
         k = {2'b00, d[4:0], 1'b1};
      end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
         d = c - CH_UP_A;
         k = {2'b00, d[4:0], 1'b0};
      end else begin
         k = {1'b1, c};
      end
      return k;
   endfunction

endpackage

// ===== hdl/longest_string_letter_sort.sv =====
// Name characters: one transaction per cycle, back to back; busy stays low.
// End of list: busy while the sort runs, n passes for n = letters of the
// longest name (at most MAX_LEN, 64 by default); one pass of the shared compare
// unit over the stored name per emitted letter.
// Results are strobed for one cycle each; the receiver cannot stall.
// Synchronous active-high reset clears lengths, counters and the sequencer.
module longest_string_letter_sort import lss_pkg::*; #(
   parameter int MAX_LEN   = MAX_LEN_DEF,
   parameter int MAX_NAMES = MAX_NAMES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_data,
   output logic    busy,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int LEN_W = $clog2(MAX_LEN + 1);
   localparam int AW    = $clog2(MAX_LEN);

   // Two name buffers swap roles: the one being filled becomes the best
   // name by flipping the bank selects, so no copy is needed.
   logic [LEN_W-1:0] cur_len_ff, cur_len_in;
   logic [LEN_W-1:0] best_len_ff, best_len_in;
   logic [7:0]       name_cnt_ff, name_cnt_in;
   logic [7:0]       best_pos_ff, best_pos_in;
   logic             cur_sel_ff, cur_sel_in;
   logic             best_sel_ff, best_sel_in;

   logic             accept;
   logic             room;
   logic             name_end;
   logic             replace;
   logic [LEN_W-1:0] len_after;
   logic             sort_start;
   logic [LEN_W-1:0] sort_len;
   logic [7:0]       sort_pos;
   logic [AW-1:0]    rd_addr;
   logic [6:0]       rd_data0, rd_data1, rd_data;

   assign accept    = start && !busy;
   assign room      = (cur_len_ff < LEN_W'(MAX_LEN));
   assign name_end  = req_data.end_of_name || req_data.end_of_list;
   assign len_after = room ? cur_len_ff + LEN_W'(1) : cur_len_ff;
   assign replace   = name_end && (len_after > best_len_ff);

   // Hand the finished list to the sorter with the winner of this last name.
   assign sort_start = accept && req_data.end_of_list;
   assign sort_len   = replace ? len_after : best_len_ff;
   assign sort_pos   = replace ? name_cnt_ff : best_pos_ff;

   always_comb begin
      cur_len_in  = cur_len_ff;
      best_len_in = best_len_ff;
      name_cnt_in = name_cnt_ff;
      best_pos_in = best_pos_ff;
      cur_sel_in  = cur_sel_ff;
      best_sel_in = best_sel_ff;
      if (accept) begin
         cur_len_in = len_after;
         if (name_end) begin
            if (replace) begin
               best_len_in = len_after;
               best_pos_in = name_cnt_ff;
               best_sel_in = cur_sel_ff;
               cur_sel_in  = !cur_sel_ff;
            end
            cur_len_in  = '0;
            name_cnt_in = (name_cnt_ff == 8'(MAX_NAMES - 1)) ? 8'd0 : name_cnt_ff + 8'd1;
         end
         // Drop the list state once it goes to the sorter.
         if (req_data.end_of_list) begin
            best_len_in = '0;
            best_pos_in = 8'd0;
            name_cnt_in = 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_len_ff  <= '0;
         best_len_ff <= '0;
         name_cnt_ff <= 8'd0;
         best_pos_ff <= 8'd0;
         cur_sel_ff  <= 1'b0;
         best_sel_ff <= 1'b1;
      end else begin
         cur_len_ff  <= cur_len_in;
         best_len_ff <= best_len_in;
         name_cnt_ff <= name_cnt_in;
         best_pos_ff <= best_pos_in;
         cur_sel_ff  <= cur_sel_in;
         best_sel_ff <= best_sel_in;
      end
   end

   lss_ram #(.WIDTH(7), .DEPTH(MAX_LEN)) u_bank0 (
      .clock   (clock),
      .wr_en   (accept && room && !cur_sel_ff),
      .wr_addr (cur_len_ff[AW-1:0]),
      .wr_data (req_data.letter),
      .rd_addr (rd_addr),
      .rd_data (rd_data0)
   );

   lss_ram #(.WIDTH(7), .DEPTH(MAX_LEN)) u_bank1 (
      .clock   (clock),
      .wr_en   (accept && room && cur_sel_ff),
      .wr_addr (cur_len_ff[AW-1:0]),
      .wr_data (req_data.letter),
      .rd_addr (rd_addr),
      .rd_data (rd_data1)
   );

   // Bank selects hold while the sorter runs: no transaction is taken then.
   assign rd_data = best_sel_ff ? rd_data1 : rd_data0;

   lss_sorter #(.MAX_LEN(MAX_LEN)) u_sorter (
      .clock      (clock),
      .reset      (reset),
      .start      (sort_start),
      .length     (sort_len),
      .position   (sort_pos),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   a_eol_starts_sort: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.end_of_list) |=> busy)
      else $error("end of list did not start the sort");

   a_rsp_from_sort: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result strobe without a running sort");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.last_letter) |-> !busy)
      else $error("sorter still busy after the final letter");

   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.last_letter) |-> busy)
      else $error("sorter stopped before the final letter");

endmodule

// ===== hdl/lss_ram.sv =====
module lss_ram #(
   parameter int WIDTH = 7,
   parameter int DEPTH = 64,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== hdl/lss_sorter.sv =====
module lss_sorter import lss_pkg::*; #(
   parameter int MAX_LEN = MAX_LEN_DEF,
   localparam int LEN_W  = $clog2(MAX_LEN + 1),
   localparam int AW     = $clog2(MAX_LEN)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [LEN_W-1:0] length,
   input  logic [7:0]       position,
   output logic [AW-1:0]    rd_addr,
   input  logic [6:0]       rd_data,
   output logic             busy,
   output logic             rsp_strobe,
   output rsp_type          rsp_data
);

   localparam int KW = 8 + AW;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type        state_ff, state_in;
   logic [LEN_W-1:0] n_ff, n_in;
   logic [7:0]       pos_ff, pos_in;
   logic [LEN_W-1:0] pass_ff, pass_in;
   logic [LEN_W-1:0] addr_ff, addr_in;
   logic             rd_vld_ff, rd_vld_in;
   logic [AW-1:0]    rd_idx_ff, rd_idx_in;
   logic             have_prev_ff, have_prev_in;
   logic [KW-1:0]    prev_ff, prev_in;
   logic             have_best_ff, have_best_in;
   logic [KW-1:0]    best_ff, best_in;
   logic [6:0]       letter_ff, letter_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   rsp_type          rsp_ff, rsp_in;
   logic [KW-1:0]    cand;
   logic             last_pass;

   assign cand      = {sort_key(rd_data), rd_idx_ff};
   assign last_pass = (pass_ff == n_ff - LEN_W'(1));
   assign rd_addr   = addr_ff[AW-1:0];

   always_comb begin
      state_in      = state_ff;
      n_in          = n_ff;
      pos_in        = pos_ff;
      pass_in       = pass_ff;
      addr_in       = addr_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = rd_idx_ff;
      have_prev_in  = have_prev_ff;
      prev_in       = prev_ff;
      have_best_in  = have_best_ff;
      best_in       = best_ff;
      letter_in     = letter_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in     = ST_SCAN;
               n_in         = length;
               pos_in       = position;
               pass_in      = '0;
               addr_in      = '0;
               have_prev_in = 1'b0;
               have_best_in = 1'b0;
            end
         end
         ST_SCAN: begin
            // issue reads for the pass
            if (addr_ff < n_ff) begin
               rd_vld_in = 1'b1;
               rd_idx_in = addr_ff[AW-1:0];
               addr_in   = addr_ff + LEN_W'(1);
            end
            // keep the smallest entry above the previous pick
            if (rd_vld_ff) begin
               if ((!have_prev_ff || cand > prev_ff) && (!have_best_ff || cand < best_ff)) begin
                  best_in      = cand;
                  letter_in    = rd_data;
                  have_best_in = 1'b1;
               end
            end
            if (addr_ff == n_ff && !rd_vld_ff) begin
               rsp_strobe_in        = 1'b1;
               rsp_in.sorted_letter = letter_ff;
               rsp_in.name_index    = pos_ff;
               rsp_in.last_letter   = last_pass;
               prev_in              = best_ff;
               have_prev_in         = 1'b1;
               have_best_in         = 1'b0;
               addr_in              = '0;
               pass_in              = pass_ff + LEN_W'(1);
               if (last_pass) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rd_vld_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         have_prev_ff  <= 1'b0;
         have_best_ff  <= 1'b0;
         addr_ff       <= '0;
         pass_ff       <= '0;
         n_ff          <= '0;
      end else begin
         state_ff      <= state_in;
         rd_vld_ff     <= rd_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
         have_prev_ff  <= have_prev_in;
         have_best_ff  <= have_best_in;
         addr_ff       <= addr_in;
         pass_ff       <= pass_in;
         n_ff          <= n_in;
      end
      pos_ff    <= pos_in;
      rd_idx_ff <= rd_idx_in;
      prev_ff   <= prev_in;
      best_ff   <= best_in;
      letter_ff <= letter_in;
      rsp_ff    <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule
